// ===== hw/rtl/slc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants of the streaming leader clusterer.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int DEF_SLOTS      = 64;
  localparam int DEF_MAX_REPORT = 8;
  localparam int DEF_COORD_BITS = 24;

  localparam int RAD_W   = 23;
  localparam int CNT_W   = 16;
  localparam int ALPHA_W = 17;
  localparam int LIM_W   = 4;
  localparam int KIND_W  = 2;
  localparam int TYPE_W  = 2;
  localparam int OSLOT_W = 6;
  localparam int CIDX_W  = 2;
  localparam int CFG_W   = 23;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;

  localparam logic [RAD_W-1:0]   RADIUS_RST = 23'd32768;
  localparam logic [CNT_W-1:0]   MINM_RST   = 16'd5;
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 17'd655;
  localparam logic [LIM_W-1:0]   LIMIT_RST  = 4'd4;

  localparam logic [CIDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MINM   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_ALPHA  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_LIMIT  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_POINT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [TYPE_W-1:0] RES_ACK   = 2'd0;
  localparam logic [TYPE_W-1:0] RES_ENTRY = 2'd1;
  localparam logic [TYPE_W-1:0] RES_EMPTY = 2'd2;

  typedef struct packed {
    logic shift;
    logic start;
    logic report;
    logic first;
  } proc_ctl_t;

endpackage

// ===== hw/rtl/slc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_cell
// One table slot of the ring: holds a cluster record and passes it on.
// ----------------------------------------------------------------------------
module slc_cell #(
  parameter int W = 2 * slc_pkg::DEF_COORD_BITS + slc_pkg::CNT_W + 1
) (
  input  logic         clk,
  input  logic         shift,
  input  logic [W-1:0] rec_in,
  output logic [W-1:0] rec_out
);

  logic [W-1:0] rec_r;
  logic [W-1:0] rec_nxt;

  assign rec_nxt = shift ? rec_in : rec_r;

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_out = rec_r;

endmodule

// ===== hw/rtl/slc_proc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_proc
// Three-stage processing head of the ring: distance test, centre blend,
// cluster creation and top-count selection.
// ----------------------------------------------------------------------------
module slc_proc #(
  parameter int SLOTS      = slc_pkg::DEF_SLOTS,
  parameter int COORD_BITS = slc_pkg::DEF_COORD_BITS,
  localparam int SW = $clog2(SLOTS),
  localparam int RW = 2 * COORD_BITS + slc_pkg::CNT_W + 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slc_pkg::proc_ctl_t                  ctl,
  input  logic [RW-1:0]                       rec_in,
  input  logic                                tag_real,
  input  logic [SW-1:0]                       tag_slot,
  input  logic [COORD_BITS-1:0]               px,
  input  logic [COORD_BITS-1:0]               py,
  input  logic [slc_pkg::RAD_W-1:0]           radius,
  input  logic [slc_pkg::ALPHA_W-1:0]         alpha,
  input  logic [slc_pkg::CNT_W-1:0]           min_members,
  input  logic [SW:0]                         used,
  input  logic [SW-1:0]                       prev_slot,
  output logic [RW-1:0]                       rec_out,
  output logic                                matched,
  output logic                                created,
  output logic                                found,
  output logic [SW-1:0]                       res_slot,
  output logic [COORD_BITS-1:0]               res_x,
  output logic [COORD_BITS-1:0]               res_y,
  output logic [slc_pkg::CNT_W-1:0]           res_cnt,
  output logic [SW-1:0]                       best_slot,
  output logic [COORD_BITS-1:0]               best_x,
  output logic [COORD_BITS-1:0]               best_y,
  output logic [slc_pkg::CNT_W-1:0]           best_cnt
);
  import slc_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;
  localparam int PW  = DW + ALPHA_W + 1;
  localparam int SQW = 2 * RAD_W;
  localparam logic signed [PW-1:0] ROUND = PW'(32768);

  // stage 1: differences and box test
  logic [CB-1:0]         x_in, y_in;
  logic signed [DW-1:0]  dx_c, dy_c;
  logic [DW-1:0]         adx_c, ady_c;
  logic                  near_c, valid_c;

  logic [RW-1:0]         s1_rec_r;
  logic                  s1_real_r, s1_valid_r, s1_near_r;
  logic [SW-1:0]         s1_slot_r;
  logic signed [DW-1:0]  s1_dx_r, s1_dy_r;
  logic [DW-1:0]         s1_adx_r, s1_ady_r;

  // stage 2: squares
  logic [32:0]           adx_w, ady_w;
  logic [RW-1:0]         s2_rec_r;
  logic                  s2_real_r, s2_valid_r, s2_near_r;
  logic [SW-1:0]         s2_slot_r;
  logic signed [DW-1:0]  s2_dx_r, s2_dy_r;
  logic [SQW-1:0]        s2_sqx_r, s2_sqy_r;
  logic [SQW-1:0]        rsq_r;

  // stage 3: match decision and blend products
  logic                  hit_c, take_c;
  logic [ALPHA_W-1:0]    a_c;
  logic [RW-1:0]         s3_rec_r;
  logic                  s3_real_r, s3_valid_r, s3_take_r;
  logic [SW-1:0]         s3_slot_r;
  logic signed [PW-1:0]  s3_pdx_r, s3_pdy_r;

  // ring write-back
  logic [CB-1:0]         x3, y3, newx, newy;
  logic [CNT_W-1:0]      cnt3, cnt_inc;
  logic                  pk3, pk_new, qual, upd, create_c;
  logic signed [PW-1:0]  sumx, sumy, stepx, stepy;

  logic                  matched_r, matched_nxt;
  logic                  created_r, created_nxt;
  logic                  found_r, found_nxt;
  logic [SW-1:0]         res_slot_r, best_slot_r;
  logic [CB-1:0]         res_x_r, res_y_r, best_x_r, best_y_r;
  logic [CNT_W-1:0]      res_cnt_r, best_cnt_r;

  assign x_in    = rec_in[CB-1:0];
  assign y_in    = rec_in[2*CB-1:CB];
  assign dx_c    = {px[CB-1], px} - {x_in[CB-1], x_in};
  assign dy_c    = {py[CB-1], py} - {y_in[CB-1], y_in};
  assign adx_c   = dx_c[DW-1] ? DW'(-dx_c) : dx_c;
  assign ady_c   = dy_c[DW-1] ? DW'(-dy_c) : dy_c;
  assign near_c  = (33'(adx_c) < 33'(radius)) && (33'(ady_c) < 33'(radius));
  assign valid_c = tag_real && ({1'b0, tag_slot} < used);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_real_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      s1_near_r  <= 1'b0;
      s2_real_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_near_r  <= 1'b0;
      s3_real_r  <= 1'b0;
      s3_valid_r <= 1'b0;
      s3_take_r  <= 1'b0;
    end else if (ctl.shift) begin
      s1_real_r  <= tag_real;
      s1_valid_r <= valid_c;
      s1_near_r  <= near_c;
      s2_real_r  <= s1_real_r;
      s2_valid_r <= s1_valid_r;
      s2_near_r  <= s1_near_r;
      s3_real_r  <= s2_real_r;
      s3_valid_r <= s2_valid_r;
      s3_take_r  <= take_c;
    end
  end

  assign adx_w = 33'(s1_adx_r);
  assign ady_w = 33'(s1_ady_r);

  always_ff @(posedge clk) begin
    rsq_r <= radius * radius;
    if (ctl.shift) begin
      s1_rec_r  <= rec_in;
      s1_slot_r <= tag_slot;
      s1_dx_r   <= dx_c;
      s1_dy_r   <= dy_c;
      s1_adx_r  <= adx_c;
      s1_ady_r  <= ady_c;
      s2_rec_r  <= s1_rec_r;
      s2_slot_r <= s1_slot_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_sqx_r  <= adx_w[RAD_W-1:0] * adx_w[RAD_W-1:0];
      s2_sqy_r  <= ady_w[RAD_W-1:0] * ady_w[RAD_W-1:0];
      s3_rec_r  <= s2_rec_r;
      s3_slot_r <= s2_slot_r;
      s3_pdx_r  <= s2_dx_r * $signed({1'b0, a_c});
      s3_pdy_r  <= s2_dy_r * $signed({1'b0, a_c});
    end
  end

  // Only the first matching slot in ascending order takes the point.
  assign hit_c  = s2_valid_r && s2_near_r &&
                  ((SQW+1)'(s2_sqx_r) + (SQW+1)'(s2_sqy_r) < (SQW+1)'(rsq_r));
  assign take_c = !ctl.report && hit_c && !matched_r;
  assign a_c    = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;

  assign x3    = s3_rec_r[CB-1:0];
  assign y3    = s3_rec_r[2*CB-1:CB];
  assign cnt3  = s3_rec_r[2*CB+CNT_W-1:2*CB];
  assign pk3   = s3_rec_r[RW-1];
  assign sumx  = s3_pdx_r + ROUND;
  assign sumy  = s3_pdy_r + ROUND;
  assign stepx = sumx >>> 16;
  assign stepy = sumy >>> 16;
  assign newx  = x3 + stepx[CB-1:0];
  assign newy  = y3 + stepy[CB-1:0];
  assign cnt_inc = (cnt3 == CNT_MAX) ? cnt3 : cnt3 + 1'b1;

  // The free slot sits behind every used one, so all match decisions are in.
  assign create_c = !ctl.report && s3_real_r && ({1'b0, s3_slot_r} == used) &&
                    (used < (SW+1)'(SLOTS)) && !matched_r;

  assign pk_new = ctl.first ? 1'b0 : (pk3 || (s3_slot_r == prev_slot));
  assign qual   = ctl.report && s3_valid_r && (cnt3 >= min_members) && !pk_new;
  assign upd    = qual && (!found_r || (cnt3 > best_cnt_r));

  always_comb begin
    rec_out = s3_rec_r;
    if (ctl.report) begin
      rec_out = {pk_new, cnt3, y3, x3};
    end else if (s3_take_r) begin
      rec_out = {pk3, cnt_inc, newy, newx};
    end else if (create_c) begin
      rec_out = {1'b0, CNT_W'(1), py, px};
    end
  end

  always_comb begin
    matched_nxt = matched_r;
    created_nxt = created_r;
    found_nxt   = found_r;
    if (ctl.start) begin
      matched_nxt = 1'b0;
      created_nxt = 1'b0;
      found_nxt   = 1'b0;
    end else if (ctl.shift) begin
      matched_nxt = matched_r || take_c;
      created_nxt = created_r || create_c;
      found_nxt   = found_r || upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r <= 1'b0;
      created_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      matched_r <= matched_nxt;
      created_r <= created_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      if (s3_take_r && !ctl.report) begin
        res_slot_r <= s3_slot_r;
        res_x_r    <= newx;
        res_y_r    <= newy;
        res_cnt_r  <= cnt_inc;
      end else if (create_c) begin
        res_slot_r <= s3_slot_r;
        res_x_r    <= px;
        res_y_r    <= py;
        res_cnt_r  <= CNT_W'(1);
      end
      if (upd) begin
        best_slot_r <= s3_slot_r;
        best_x_r    <= x3;
        best_y_r    <= y3;
        best_cnt_r  <= cnt3;
      end
    end
  end

  assign matched   = matched_r;
  assign created   = created_r;
  assign found     = found_r;
  assign res_slot  = res_slot_r;
  assign res_x     = res_x_r;
  assign res_y     = res_y_r;
  assign res_cnt   = res_cnt_r;
  assign best_slot = best_slot_r;
  assign best_x    = best_x_r;
  assign best_y    = best_y_r;
  assign best_cnt  = best_cnt_r;

endmodule

// ===== hw/rtl/streaming_leader_clusterer_top.sv =====
`timescale 1ns / 1ps
// Point: from acceptance to a valid result: one ring rotation through the cluster
//   cells and the three-stage head, then the result is loaded. The next transaction
//   is taken only once the result is loaded.
// Report: one ring rotation per selected entry, plus one more rotation when fewer
//   entries qualify than the limit, or a pass through S_FLUSH when the limit is reached.
// Clear and reset empty the table. Output stalls can hold points and reports.
// ----------------------------------------------------------------------------
// streaming_leader_clusterer_top
// Online leader clustering of 2-D points over a ring of cluster cells.
// ----------------------------------------------------------------------------
module streaming_leader_clusterer_top #(
  parameter int SLOTS      = slc_pkg::DEF_SLOTS,
  parameter int MAX_REPORT = slc_pkg::DEF_MAX_REPORT,
  parameter int COORD_BITS = slc_pkg::DEF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [slc_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [slc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [slc_pkg::KIND_W-1:0]    in_kind,
  input  logic [COORD_BITS-1:0]         in_point_x,
  input  logic [COORD_BITS-1:0]         in_point_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [slc_pkg::TYPE_W-1:0]    out_result_type,
  output logic [slc_pkg::OSLOT_W-1:0]   out_slot,
  output logic                          out_created,
  output logic                          out_dropped,
  output logic [COORD_BITS-1:0]         out_centre_x,
  output logic [COORD_BITS-1:0]         out_centre_y,
  output logic [slc_pkg::CNT_W-1:0]     out_members,
  output logic                          out_last
);
  import slc_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int RW = 2 * COORD_BITS + CNT_W + 1;
  localparam int L  = SLOTS + 3;
  localparam int CW = $clog2(L);
  localparam int KW = $clog2(MAX_REPORT + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PASS  = 4'b0010,
    S_DONE  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [RAD_W-1:0]   radius_r;
  logic [CNT_W-1:0]   minm_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [LIM_W-1:0]   limit_r;

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [SW:0]        used_r, used_nxt;
  logic               report_r, report_nxt;
  logic               first_r, first_nxt;
  logic [KW-1:0]      k_r, k_nxt, lim;
  logic               pend_r, pend_nxt;
  logic [SW-1:0]      pend_slot_r, prev_slot_r;
  logic [COORD_BITS-1:0] pend_x_r, pend_y_r, px_r, py_r;
  logic [CNT_W-1:0]   pend_cnt_r;
  logic               load_pend, load_prev, take_pt;

  logic               out_valid_r, out_valid_nxt, out_free, out_load;
  logic [TYPE_W-1:0]  o_type_r, o_type_nxt;
  logic [OSLOT_W-1:0] o_slot_r, o_slot_nxt;
  logic               o_created_r, o_created_nxt, o_dropped_r, o_dropped_nxt;
  logic [COORD_BITS-1:0] o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  logic [CNT_W-1:0]   o_cnt_r, o_cnt_nxt;
  logic               o_last_r, o_last_nxt;

  proc_ctl_t          ctl;
  logic [RW-1:0]      ring [SLOTS];
  logic [RW-1:0]      proc_out;
  logic               matched, created, found;
  logic [SW-1:0]      res_slot, best_slot;
  logic [COORD_BITS-1:0] res_x, res_y, best_x, best_y;
  logic [CNT_W-1:0]   res_cnt, best_cnt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      minm_r   <= MINM_RST;
      alpha_r  <= ALPHA_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS: radius_r <= cfg_wdata[RAD_W-1:0];
        REG_MINM:   minm_r   <= cfg_wdata[CNT_W-1:0];
        REG_ALPHA:  alpha_r  <= cfg_wdata[ALPHA_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (limit_r == '0) begin
      lim = KW'(1);
    end else if (32'(limit_r) > MAX_REPORT) begin
      lim = KW'(MAX_REPORT);
    end else begin
      lim = KW'(limit_r);
    end
  end

  // the ring of cluster cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      slc_cell #(.W(RW)) u_cell (
        .clk     (clk),
        .shift   (ctl.shift),
        .rec_in  (proc_out),
        .rec_out (ring[i])
      );
    end else begin : g_body
      slc_cell #(.W(RW)) u_cell (
        .clk     (clk),
        .shift   (ctl.shift),
        .rec_in  (ring[i+1]),
        .rec_out (ring[i])
      );
    end
  end

  slc_proc #(.SLOTS(SLOTS), .COORD_BITS(COORD_BITS)) u_proc (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .rec_in      (ring[0]),
    .tag_real    (32'(cnt_r) < SLOTS),
    .tag_slot    (cnt_r[SW-1:0]),
    .px          (px_r),
    .py          (py_r),
    .radius      (radius_r),
    .alpha       (alpha_r),
    .min_members (minm_r),
    .used        (used_r),
    .prev_slot   (prev_slot_r),
    .rec_out     (proc_out),
    .matched     (matched),
    .created     (created),
    .found       (found),
    .res_slot    (res_slot),
    .res_x       (res_x),
    .res_y       (res_y),
    .res_cnt     (res_cnt),
    .best_slot   (best_slot),
    .best_x      (best_x),
    .best_y      (best_y),
    .best_cnt    (best_cnt)
  );

  assign in_ready = (state_r == S_IDLE);
  assign take_pt  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    report_nxt    = report_r;
    first_nxt     = first_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    load_pend     = 1'b0;
    load_prev     = 1'b0;
    ctl.shift     = 1'b0;
    ctl.start     = 1'b0;
    ctl.report    = report_r;
    ctl.first     = first_r;
    out_load      = 1'b0;
    o_type_nxt    = RES_ACK;
    o_slot_nxt    = '0;
    o_created_nxt = 1'b0;
    o_dropped_nxt = 1'b0;
    o_x_nxt       = '0;
    o_y_nxt       = '0;
    o_cnt_nxt     = '0;
    o_last_nxt    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (take_pt) begin
          cnt_nxt = '0;
          unique case (in_kind)
            KIND_POINT: begin
              report_nxt = 1'b0;
              ctl.start  = 1'b1;
              state_nxt  = S_PASS;
            end
            KIND_REPORT: begin
              report_nxt = 1'b1;
              first_nxt  = 1'b1;
              k_nxt      = '0;
              pend_nxt   = 1'b0;
              ctl.start  = 1'b1;
              state_nxt  = S_PASS;
            end
            KIND_CLEAR: used_nxt = '0;
            default: ;
          endcase
        end
      end
      S_PASS: begin
        ctl.shift = 1'b1;
        if (cnt_r == CW'(L - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!report_r) begin
          if (out_free) begin
            out_load = 1'b1;
            if (matched || created) begin
              o_slot_nxt    = OSLOT_W'(res_slot);
              o_created_nxt = created;
              o_x_nxt       = res_x;
              o_y_nxt       = res_y;
              o_cnt_nxt     = res_cnt;
            end else begin
              o_dropped_nxt = 1'b1;
            end
            if (created) begin
              used_nxt = used_r + 1'b1;
            end
            state_nxt = S_IDLE;
          end
        end else if (found) begin
          // The held entry goes out now that another one is known to follow.
          if (!pend_r || out_free) begin
            if (pend_r) begin
              out_load      = 1'b1;
              o_type_nxt    = RES_ENTRY;
              o_slot_nxt    = OSLOT_W'(pend_slot_r);
              o_x_nxt       = pend_x_r;
              o_y_nxt       = pend_y_r;
              o_cnt_nxt     = pend_cnt_r;
              o_last_nxt    = 1'b0;
            end
            load_pend = 1'b1;
            pend_nxt  = 1'b1;
            k_nxt     = k_r + 1'b1;
            if (k_r + 1'b1 == lim) begin
              state_nxt = S_FLUSH;
            end else begin
              load_prev = 1'b1;
              first_nxt = 1'b0;
              cnt_nxt   = '0;
              ctl.start = 1'b1;
              state_nxt = S_PASS;
            end
          end
        end else if (out_free) begin
          out_load = 1'b1;
          if (pend_r) begin
            o_type_nxt = RES_ENTRY;
            o_slot_nxt = OSLOT_W'(pend_slot_r);
            o_x_nxt    = pend_x_r;
            o_y_nxt    = pend_y_r;
            o_cnt_nxt  = pend_cnt_r;
          end else begin
            o_type_nxt = RES_EMPTY;
          end
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_type_nxt = RES_ENTRY;
          o_slot_nxt = OSLOT_W'(pend_slot_r);
          o_x_nxt    = pend_x_r;
          o_y_nxt    = pend_y_r;
          o_cnt_nxt  = pend_cnt_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      used_r      <= '0;
      report_r    <= 1'b0;
      first_r     <= 1'b0;
      k_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      report_r    <= report_nxt;
      first_r     <= first_nxt;
      k_r         <= k_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_pt) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
    end
    if (load_pend) begin
      pend_slot_r <= best_slot;
      pend_x_r    <= best_x;
      pend_y_r    <= best_y;
      pend_cnt_r  <= best_cnt;
    end
    if (load_prev) begin
      prev_slot_r <= best_slot;
    end
    if (out_load) begin
      o_type_r    <= o_type_nxt;
      o_slot_r    <= o_slot_nxt;
      o_created_r <= o_created_nxt;
      o_dropped_r <= o_dropped_nxt;
      o_x_r       <= o_x_nxt;
      o_y_r       <= o_y_nxt;
      o_cnt_r     <= o_cnt_nxt;
      o_last_r    <= o_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_type = o_type_r;
  assign out_slot        = o_slot_r;
  assign out_created     = o_created_r;
  assign out_dropped     = o_dropped_r;
  assign out_centre_x    = o_x_r;
  assign out_centre_y    = o_y_r;
  assign out_members     = o_cnt_r;
  assign out_last        = o_last_r;

endmodule

// ===== verif/tb_streaming_leader_clusterer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_streaming_leader_clusterer_top
// Drives points, reports and clears into the leader clusterer under several
// register settings. A predictor keeps its own cluster table and queues the
// expected acknowledges and report entries. Both handshake sides idle at
// random, and every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_streaming_leader_clusterer_top;
  import slc_pkg::*;

  localparam int NSLOT = 64;
  localparam int CB = 24;
  localparam int REP_MAX = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int EXP_DEPTH = 64;
  localparam int NROWS = 32;
  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0]  rtype;
    logic [OSLOT_W-1:0] slot;
    logic               created;
    logic               dropped;
    logic [CB-1:0]      cx;
    logic [CB-1:0]      cy;
    logic [CNT_W-1:0]   members;
    logic               last;
  } cluster_res_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [CB-1:0]     x;
    logic [CB-1:0]     y;
    bit                typed;
    cluster_res_t      res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [CB-1:0] in_point_x = '0;
  logic [CB-1:0] in_point_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TYPE_W-1:0] out_result_type;
  logic [OSLOT_W-1:0] out_slot;
  logic out_created;
  logic out_dropped;
  logic [CB-1:0] out_centre_x;
  logic [CB-1:0] out_centre_y;
  logic [CNT_W-1:0] out_members;
  logic out_last;

  streaming_leader_clusterer_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_type(out_result_type), .out_slot(out_slot),
    .out_created(out_created), .out_dropped(out_dropped),
    .out_centre_x(out_centre_x), .out_centre_y(out_centre_y),
    .out_members(out_members), .out_last(out_last)
  );

  always #4 clk = ~clk;

  // Predictor state.
  longint cent_x[NSLOT];
  longint cent_y[NSLOT];
  int unsigned member_cnt[NSLOT];
  int unsigned used_cnt;
  longint join_radius;
  int unsigned min_count;
  int unsigned alpha_q16;
  int unsigned rep_limit;

  // Expected results, kept as a circular buffer.
  cluster_res_t exp_mem[EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  function automatic int exp_level();
    return exp_wr - exp_rd;
  endfunction

  function automatic void exp_put(cluster_res_t r);
    exp_mem[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic cluster_res_t exp_take();
    cluster_res_t r;
    r = exp_mem[exp_rd % EXP_DEPTH];
    exp_rd++;
    return r;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic longint blend(longint d, longint a);
    return (d * a + 64'sd32768) >>> 16;
  endfunction

  function automatic bit joins(longint px, longint py, longint cx, longint cy);
    longint dx, dy;
    dx = px - cx;
    dy = py - cy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx >= join_radius || dy >= join_radius) return 1'b0;
    return (dx * dx + dy * dy) < (join_radius * join_radius);
  endfunction

  function automatic void predict_clusters(logic [KIND_W-1:0] kind,
                                           logic [CB-1:0] x, logic [CB-1:0] y);
    cluster_res_t r;
    longint px, py, a;
    int unsigned lim, best, k;
    bit found, hit;
    bit picked[NSLOT];
    px = longint'($signed(x));
    py = longint'($signed(y));
    a = (alpha_q16 > 65536) ? 64'sd65536 : longint'(alpha_q16);
    r = '0;
    hit = 1'b0;
    if (kind == KIND_POINT) begin
      for (int i = 0; i < used_cnt && !hit; i++) begin
        if (joins(px, py, cent_x[i], cent_y[i])) begin
          cent_x[i] += blend(px - cent_x[i], a);
          cent_y[i] += blend(py - cent_y[i], a);
          if (member_cnt[i] < 65535) member_cnt[i]++;
          r.slot = OSLOT_W'(i);
          r.cx = cent_x[i][CB-1:0];
          r.cy = cent_y[i][CB-1:0];
          r.members = CNT_W'(member_cnt[i]);
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (used_cnt >= NSLOT) begin
          r.dropped = 1'b1;
        end else begin
          cent_x[used_cnt] = px;
          cent_y[used_cnt] = py;
          member_cnt[used_cnt] = 1;
          r.slot = OSLOT_W'(used_cnt);
          r.created = 1'b1;
          r.cx = x;
          r.cy = y;
          r.members = CNT_W'(1);
          used_cnt++;
        end
      end
      r.rtype = RES_ACK;
      r.last = 1'b1;
      exp_put(r);
    end else if (kind == KIND_REPORT) begin
      lim = (rep_limit < 1) ? 1 : (rep_limit > REP_MAX) ? REP_MAX : rep_limit;
      foreach (picked[i]) picked[i] = 1'b0;
      k = 0;
      found = 1'b1;
      while (k < lim && found) begin
        found = 1'b0;
        best = 0;
        for (int i = 0; i < used_cnt; i++) begin
          if (!picked[i] && member_cnt[i] >= min_count &&
              (!found || member_cnt[i] > member_cnt[best])) begin
            best = i;
            found = 1'b1;
          end
        end
        if (found) begin
          picked[best] = 1'b1;
          r = '0;
          r.rtype = RES_ENTRY;
          r.slot = OSLOT_W'(best);
          r.cx = cent_x[best][CB-1:0];
          r.cy = cent_y[best][CB-1:0];
          r.members = CNT_W'(member_cnt[best]);
          exp_put(r);
          k++;
        end
      end
      if (k == 0) begin
        r = '0;
        r.rtype = RES_EMPTY;
        r.last = 1'b1;
        exp_put(r);
      end else begin
        exp_mem[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
      end
    end else if (kind == KIND_CLEAR) begin
      used_cnt = 0;
    end
  endfunction

  task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    case (idx)
      REG_RADIUS: join_radius = longint'(val & 32'h7FFFFF);
      REG_MINM:   min_count = val & 32'hFFFF;
      REG_ALPHA:  alpha_q16 = val & 32'h1FFFF;
      REG_LIMIT:  rep_limit = val & 32'hF;
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned rad, int unsigned mm, int unsigned al,
                            int unsigned lim);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_MINM, mm);
    write_reg(REG_ALPHA, al);
    write_reg(REG_LIMIT, lim);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Presents one transaction after a random gap and predicts it on acceptance.
  task automatic send(logic [KIND_W-1:0] kind, logic [CB-1:0] x, logic [CB-1:0] y,
                      bit typed = 1'b0, cluster_res_t res = '0);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_point_x <= x;
    in_point_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_clusters(kind, x, y);
    if (typed && exp_level() > 0) begin
      exp_mem[(exp_wr - 1) % EXP_DEPTH] = res;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_level() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] clamp_coord(longint v);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v[CB-1:0];
  endfunction

  // Mostly points scattered around a few seeds, with reports, clears and noise.
  task automatic random_phase(int count);
    longint seed_x[4], seed_y[4], spread;
    int pick, s;
    no_idle = ($urandom_range(0, 3) == 0);
    spread = (join_radius < 64) ? 64 : join_radius;
    foreach (seed_x[i]) begin
      seed_x[i] = longint'($signed(24'($urandom)));
      seed_y[i] = longint'($signed(24'($urandom)));
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      s = $urandom_range(0, 3);
      if (pick < 10) send(KIND_REPORT, '0, '0);
      else if (pick < 12) send(KIND_CLEAR, 24'($urandom), 24'($urandom));
      else if (pick < 14) send(KIND_NOP, 24'($urandom), 24'($urandom));
      else if (pick < 24) send(KIND_POINT, 24'($urandom), 24'($urandom));
      else send(KIND_POINT,
                clamp_coord(seed_x[s] + longint'($urandom_range(0, 2 * spread)) - spread),
                clamp_coord(seed_y[s] + longint'($urandom_range(0, 2 * spread)) - spread));
    end
    send(KIND_REPORT, '0, '0);
    drain();
  endtask

  // Receiver with random stalls; checks each result against the oldest one queued.
  initial begin
    cluster_res_t got, want;
    int stall;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && rst_n)) @(posedge clk);
      got = '{out_result_type, out_slot, out_created, out_dropped,
              out_centre_x, out_centre_y, out_members, out_last};
      if (exp_level() == 0) begin
        $error("unexpected result transaction: %p", got);
        errors++;
      end else begin
        want = exp_take();
        if (got.rtype !== want.rtype) begin
          $error("result_type expected %0d got %0d", want.rtype, got.rtype); errors++;
        end
        if (got.slot !== want.slot) begin
          $error("slot expected %0d got %0d", want.slot, got.slot); errors++;
        end
        if (got.created !== want.created) begin
          $error("created expected %0d got %0d", want.created, got.created); errors++;
        end
        if (got.dropped !== want.dropped) begin
          $error("dropped expected %0d got %0d", want.dropped, got.dropped); errors++;
        end
        if (got.cx !== want.cx) begin
          $error("centre_x expected %0h got %0h", want.cx, got.cx); errors++;
        end
        if (got.cy !== want.cy) begin
          $error("centre_y expected %0h got %0h", want.cy, got.cy); errors++;
        end
        if (got.members !== want.members) begin
          $error("members expected %0d got %0d", want.members, got.members); errors++;
        end
        if (got.last !== want.last) begin
          $error("last expected %0d got %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  stim_row_t directed[NROWS];
  int nrows = 0;

  function automatic void add_row(stim_row_t row);
    directed[nrows] = row;
    nrows++;
  endfunction

  initial begin
    cluster_res_t empty_res;
    empty_res = '{RES_EMPTY, '0, 1'b0, 1'b0, '0, '0, '0, 1'b1};
    used_cnt = 0;
    join_radius = longint'(RADIUS_RST);
    min_count = MINM_RST;
    alpha_q16 = ALPHA_RST;
    rep_limit = LIMIT_RST;
    foreach (cent_x[i]) begin
      cent_x[i] = 0; cent_y[i] = 0; member_cnt[i] = 0;
    end

    add_row('{KIND_REPORT, '0, '0, 1'b1, empty_res});
    add_row('{KIND_POINT, 24'h7FFFFF, 24'h7FFFFF, 1'b1,
              '{RES_ACK, 6'd0, 1'b1, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 16'd1, 1'b1}});
    add_row('{KIND_POINT, 24'h800000, 24'h800000, 1'b1,
              '{RES_ACK, 6'd1, 1'b1, 1'b0, 24'h800000, 24'h800000, 16'd1, 1'b1}});
    add_row('{KIND_POINT, 24'h000000, 24'h000000, 1'b1,
              '{RES_ACK, 6'd2, 1'b1, 1'b0, 24'h000000, 24'h000000, 16'd1, 1'b1}});
    add_row('{KIND_POINT, 24'd100, -24'sd100, 1'b0, '0});
    add_row('{KIND_POINT, 24'd32768, 24'd0, 1'b0, '0});   // at the radius from the origin
    add_row('{KIND_POINT, 24'd32767, 24'd0, 1'b0, '0});   // just inside
    add_row('{KIND_POINT, 24'd23170, 24'd23170, 1'b0, '0});
    add_row('{KIND_NOP, 24'h123456, 24'h654321, 1'b0, '0});
    add_row('{KIND_REPORT, '0, '0, 1'b0, '0});
    add_row('{KIND_POINT, -24'sd5, 24'd7, 1'b0, '0});
    add_row('{KIND_POINT, 24'h7FFFF0, 24'h7FFFF0, 1'b0, '0});
    add_row('{KIND_POINT, 24'd1, 24'd1, 1'b0, '0});
    add_row('{KIND_POINT, -24'sd1, -24'sd1, 1'b0, '0});
    add_row('{KIND_POINT, 24'd10, 24'd10, 1'b0, '0});
    add_row('{KIND_POINT, 24'h7FFFF8, 24'h7FFFFF, 1'b0, '0});
    add_row('{KIND_REPORT, '0, '0, 1'b0, '0});
    add_row('{KIND_CLEAR, '0, '0, 1'b0, '0});
    add_row('{KIND_REPORT, '0, '0, 1'b1, empty_res});
    add_row('{KIND_POINT, 24'h555555, 24'hAAAAAA, 1'b1,
              '{RES_ACK, 6'd0, 1'b1, 1'b0, 24'h555555, 24'hAAAAAA, 16'd1, 1'b1}});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < nrows; i++)
      send(directed[i].kind, directed[i].x, directed[i].y,
           directed[i].typed, directed[i].res);
    drain();

    random_phase(60);
    set_config(0, 1, 0, 1);                 // nothing ever joins
    random_phase(40);
    set_config(8388607, 65535, 65536, 8);
    random_phase(40);
    set_config(262144, 2, 131071, 15);      // alpha above one, limit above the cap
    random_phase(60);
    set_config(1, 1, 65536, 0);             // limit of zero
    send(KIND_CLEAR, '0, '0);
    for (int n = 0; n < 66; n++)
      send(KIND_POINT, 24'($urandom), 24'($urandom));
    send(KIND_REPORT, '0, '0);
    drain();
    set_config($urandom_range(4096, 300000), $urandom_range(1, 6),
               $urandom_range(0, 65536), $urandom_range(1, 8));
    random_phase(80);

    while (exp_level() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && exp_level() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== streaming_leader_clusterer_top.f =====
hw/rtl/slc_pkg.sv
hw/rtl/slc_cell.sv
hw/rtl/slc_proc.sv
hw/rtl/streaming_leader_clusterer_top.sv
verif/tb_streaming_leader_clusterer_top.sv
